// File: rtl/tjps_pkg.sv
// Package for the two-joint position sequencer.
// Holds widths, the sequencer mode type and the angle window helper functions.
// No dependencies.
`timescale 1ns / 1ps

package tjps_pkg;

    localparam int ANGLE_BITS  = 16;
    localparam int UNW_BITS    = ANGLE_BITS + 1;
    localparam int ERR_BITS    = ANGLE_BITS + 2;
    localparam int CNT_BITS    = 32;
    localparam int NUM_REGS    = 8;
    localparam int REG_IDX_W   = $clog2(NUM_REGS);
    localparam int ARRIVE_TOLERANCE = 364;

    localparam int IN_DATA_W   = 72;
    localparam int OUT_DATA_W  = 144;

    typedef logic [ANGLE_BITS-1:0] angle_t;
    typedef logic [UNW_BITS-1:0]   unw_t;
    typedef logic [ERR_BITS-1:0]   err_t;

    typedef enum logic [2:0] {
        MODE_OFF      = 3'd0,
        MODE_GOHOME   = 3'd1,
        MODE_HOMEHOLD = 3'd2,
        MODE_GOGOAL   = 3'd3,
        MODE_GOALHOLD = 3'd4
    } mode_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_LEFT_LIMIT_START  = 3'd0,
        REG_LEFT_LIMIT_END    = 3'd1,
        REG_RIGHT_LIMIT_START = 3'd2,
        REG_RIGHT_LIMIT_END   = 3'd3,
        REG_LEFT_HOME         = 3'd4,
        REG_RIGHT_HOME        = 3'd5,
        REG_LEFT_GOAL         = 3'd6,
        REG_RIGHT_GOAL        = 3'd7
    } reg_idx_t;

    // A window with end below start wraps through zero; equal ends mean no window.
    function automatic logic in_window(angle_t s, angle_t e, angle_t a);
        logic r;
        if (s < e) begin
            r = (a >= s) && (a <= e);
        end else if (s > e) begin
            r = (a >= s) || (a <= e);
        end else begin
            r = 1'b0;
        end
        return r;
    endfunction

    // Angles below the start of a wrapping window are moved up by one turn.
    function automatic unw_t unwrap(angle_t s, angle_t e, angle_t a);
        unw_t r;
        if ((s > e) && (a < s)) begin
            r = {1'b1, a};
        end else begin
            r = {1'b0, a};
        end
        return r;
    endfunction

    function automatic logic near(unw_t r, unw_t f);
        err_t d;
        if (f >= r) begin
            d = ERR_BITS'(f) - ERR_BITS'(r);
        end else begin
            d = ERR_BITS'(r) - ERR_BITS'(f);
        end
        return d <= ERR_BITS'(ARRIVE_TOLERANCE);
    endfunction

endpackage

// File: rtl/two_joint_position_sequencer.sv
// Two-joint position sequencer, top level.
// Each accepted tick passes through the input register, then the result register, before
// m_tvalid rises for its result.
// Throughput: one item per cycle while m_tready stays high; with m_tready low the input
// stalls once both the input register and the result register hold a tick.
// Reset (aresetn low at a clock edge, synchronous) clears the registers, the mode (disabled),
// the action snapshot, the kept angles and the setpoints, and empties both pipeline registers.
// Depends on tjps_pkg.
`timescale 1ns / 1ps

module two_joint_position_sequencer (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration write port.
    input  logic                                cfg_wr_en,
    input  logic [tjps_pkg::REG_IDX_W-1:0]      cfg_addr,
    input  logic [tjps_pkg::ANGLE_BITS-1:0]     cfg_wr_data,
    // Input channel, one control tick per transfer.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata, from bit 0: left encoder angle[16], right encoder angle[16], left_link_ok,
    // right_link_ok, mechanism_on, stair_allowed, action_count[32], zero fill[4].
    input  logic [tjps_pkg::IN_DATA_W-1:0]      s_tdata,
    // Result channel, one transfer per tick.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata, from bit 0: mode[3], control_on, config_ok, left_setpoint[17],
    // right_setpoint[17], left_feedback[17], right_feedback[17], left_error[18],
    // right_error[18], left_raw_kept[16], right_raw_kept[16], zero fill[3].
    output logic [tjps_pkg::OUT_DATA_W-1:0]     m_tdata
);
    import tjps_pkg::*;

    // Configuration registers.
    angle_t cfg_reg [NUM_REGS];

    // Pipeline registers.
    logic                  in_valid_reg;
    logic [IN_DATA_W-1:0]  in_data_reg;
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    // Sequencer state.
    mode_t                 mode_reg, mode_next;
    logic [CNT_BITS-1:0]   seen_reg, seen_next;
    angle_t                raw_kept_reg [2];
    unw_t                  unw_kept_reg [2];
    unw_t                  setpoint_reg [2], setpoint_next [2];

    logic advance;

    // The tick in the input register is processed when the result register is
    // free or is being emptied in this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                cfg_reg[i] <= '0;
            end
        end else if (cfg_wr_en) begin
            cfg_reg[cfg_addr] <= cfg_wr_data;
        end
    end

    // Unpacked fields of the registered tick.
    angle_t              angle [2];
    logic                link_ok [2];
    logic                mech_on;
    logic                stair_ok;
    logic [CNT_BITS-1:0] count;

    assign angle[0]   = in_data_reg[15:0];
    assign angle[1]   = in_data_reg[31:16];
    assign link_ok[0] = in_data_reg[32];
    assign link_ok[1] = in_data_reg[33];
    assign mech_on    = in_data_reg[34];
    assign stair_ok   = in_data_reg[35];
    assign count      = in_data_reg[67:36];

    // Per-motor window checks and unwrapped references.
    angle_t win_s [2], win_e [2];
    unw_t   home_unw [2], goal_unw [2], angle_unw [2], kept_upd [2];
    logic   feed_ok [2], motor_cfg_ok [2], near_home [2], near_goal [2];
    logic   cfg_ok, at_home, at_goal, shutdown;

    always_comb begin
        for (int m = 0; m < 2; m++) begin
            win_s[m]        = cfg_reg[2*m];
            win_e[m]        = cfg_reg[2*m+1];
            home_unw[m]     = unwrap(win_s[m], win_e[m], cfg_reg[4+m]);
            goal_unw[m]     = unwrap(win_s[m], win_e[m], cfg_reg[6+m]);
            angle_unw[m]    = unwrap(win_s[m], win_e[m], angle[m]);
            feed_ok[m]      = link_ok[m] && in_window(win_s[m], win_e[m], angle[m]);
            motor_cfg_ok[m] = in_window(win_s[m], win_e[m], cfg_reg[4+m]) &&
                              in_window(win_s[m], win_e[m], cfg_reg[6+m]);
            kept_upd[m]     = feed_ok[m] ? angle_unw[m] : unw_kept_reg[m];
            near_home[m]    = near(home_unw[m], kept_upd[m]);
            near_goal[m]    = near(goal_unw[m], kept_upd[m]);
        end
        cfg_ok   = motor_cfg_ok[0] && motor_cfg_ok[1];
        at_home  = feed_ok[0] && feed_ok[1] && near_home[0] && near_home[1];
        at_goal  = feed_ok[0] && feed_ok[1] && near_goal[0] && near_goal[1];
        shutdown = !mech_on || !cfg_ok || (!feed_ok[0] && !feed_ok[1]);
    end

    // Sequencer next state. A setpoint refresh picks the goal angles when the
    // new mode is heading to or holding the goal, the home angles otherwise.
    mode_t mode_mid;
    logic  refresh;

    always_comb begin
        mode_next     = mode_reg;
        seen_next     = seen_reg;
        setpoint_next = setpoint_reg;
        mode_mid      = mode_reg;
        refresh       = 1'b0;

        if (shutdown) begin
            mode_mid  = MODE_OFF;
            mode_next = MODE_OFF;
            seen_next = count;
            refresh   = 1'b1;
        end else if (mode_reg == MODE_OFF) begin
            // Re-enable always heads home first; a pending action is absorbed.
            mode_mid  = MODE_GOHOME;
            mode_next = at_home ? MODE_HOMEHOLD : MODE_GOHOME;
            seen_next = count;
            refresh   = 1'b1;
        end else if (!stair_ok) begin
            mode_mid  = MODE_GOHOME;
            refresh   = !((mode_reg == MODE_HOMEHOLD) && at_home);
            mode_next = at_home ? MODE_HOMEHOLD : MODE_GOHOME;
            seen_next = count;
        end else begin
            if (count != seen_reg) begin
                seen_next = count;
                refresh   = 1'b1;
                if ((mode_reg == MODE_HOMEHOLD) || (mode_reg == MODE_GOHOME)) begin
                    mode_mid = MODE_GOGOAL;
                end else begin
                    mode_mid = MODE_GOHOME;
                end
            end
            mode_next = mode_mid;
            if ((mode_mid == MODE_GOGOAL) && at_goal) begin
                mode_next = MODE_GOALHOLD;
            end else if (((mode_mid == MODE_GOHOME) || (mode_mid == MODE_HOMEHOLD)) &&
                         at_home) begin
                mode_next = MODE_HOMEHOLD;
            end
        end

        if (refresh) begin
            for (int m = 0; m < 2; m++) begin
                if ((mode_mid == MODE_GOGOAL) || (mode_mid == MODE_GOALHOLD)) begin
                    setpoint_next[m] = goal_unw[m];
                end else begin
                    setpoint_next[m] = home_unw[m];
                end
            end
        end
    end

    // Result fields as they stand after this tick's update.
    angle_t raw_out [2];
    unw_t   fb_out [2];
    err_t   err_out [2];

    always_comb begin
        for (int m = 0; m < 2; m++) begin
            if (!shutdown && feed_ok[m]) begin
                raw_out[m] = angle[m];
                fb_out[m]  = angle_unw[m];
            end else begin
                raw_out[m] = raw_kept_reg[m];
                fb_out[m]  = unw_kept_reg[m];
            end
            err_out[m] = ERR_BITS'(setpoint_next[m]) - ERR_BITS'(fb_out[m]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_OFF;
            seen_reg      <= '0;
            for (int m = 0; m < 2; m++) begin
                raw_kept_reg[m] <= '0;
                unw_kept_reg[m] <= '0;
                setpoint_reg[m] <= '0;
            end
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (advance) begin
                mode_reg     <= mode_next;
                seen_reg     <= seen_next;
                setpoint_reg <= setpoint_next;
                raw_kept_reg <= raw_out;
                unw_kept_reg <= fb_out;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata;
        end
        if (advance) begin
            out_data_reg <= {3'b000, raw_out[1], raw_out[0], err_out[1], err_out[0],
                             fb_out[1], fb_out[0], setpoint_next[1], setpoint_next[0],
                             cfg_ok, (mode_next != MODE_OFF), mode_next};
        end
    end

`ifndef SYNTHESIS
    // A result with a bad configuration must report the disabled mode.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[4]) |-> (m_tdata[2:0] == MODE_OFF))
        else $error("config_ok low with an active mode");

    // control_on mirrors the reported mode.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[3] == (m_tdata[2:0] != MODE_OFF)))
        else $error("control_on disagrees with mode");

    // Setpoints and kept angles move only when a tick is processed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> ($stable(setpoint_reg[0]) && $stable(setpoint_reg[1])))
        else $error("setpoint changed without a tick");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> ($stable(unw_kept_reg[0]) && $stable(unw_kept_reg[1]) &&
                      $stable(mode_reg)))
        else $error("sequencer state changed without a tick");

    // The result register holds the state it was loaded from.
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> (m_tdata[2:0] == mode_reg))
        else $error("result mode does not match sequencer state");
`endif

endmodule

// File: tb/sv/tb_two_joint_position_sequencer.sv
// Self-checking testbench for the two-joint position sequencer.
// Depends on tjps_pkg and two_joint_position_sequencer; needs no other file.
`timescale 1ns / 1ps

module tb_two_joint_position_sequencer;

    import tjps_pkg::*;

    localparam int TURN        = 1 << ANGLE_BITS;
    localparam int SPREAD      = ARRIVE_TOLERANCE + 40;
    localparam int IDLE_PCT    = 35;
    localparam int HOLD_CYCLES = 90;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 10;
    localparam int MAX_REPORTS = 10;

    // One control tick as it travels on s_tdata, top field first.
    typedef struct packed {
        logic [3:0]          fill;
        logic [CNT_BITS-1:0] action_count;
        logic                stair_allowed;
        logic                mechanism_on;
        logic                right_link_ok;
        logic                left_link_ok;
        angle_t              right_pos;
        angle_t              left_pos;
    } tick_in_t;

    // One result as it travels on m_tdata, top field first.
    typedef struct packed {
        logic [2:0] fill;
        angle_t     right_raw_kept;
        angle_t     left_raw_kept;
        err_t       right_error;
        err_t       left_error;
        unw_t       right_feedback;
        unw_t       left_feedback;
        unw_t       right_setpoint;
        unw_t       left_setpoint;
        logic       config_ok;
        logic       control_on;
        mode_t      mode;
    } tick_out_t;

    logic                   aclk        = 1'b0;
    logic                   aresetn     = 1'b0;
    logic                   cfg_wr_en   = 1'b0;
    logic [REG_IDX_W-1:0]   cfg_addr    = REG_LEFT_LIMIT_START;
    logic [ANGLE_BITS-1:0]  cfg_wr_data = '0;
    logic                   s_tvalid    = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata     = '0;
    logic                   m_tvalid;
    logic                   m_tready    = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;

    two_joint_position_sequencer dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Shadow copy of the registers and of the sequencer state. The register copy is
    // updated as each write is driven; no tick is in flight while that happens.
    angle_t        cfg_regs [NUM_REGS] = '{default: '0};
    mode_t         mode_q     = MODE_OFF;
    logic [31:0]   seen_q     = '0;
    angle_t        raw_q [2]  = '{default: '0};
    unw_t          unw_q [2]  = '{default: '0};
    unw_t          sp_q [2]   = '{default: '0};

    tick_in_t      ticks_to_send [$];
    tick_out_t     results_due [$];

    int            ticks_queued     = 0;
    int            ticks_taken      = 0;
    int            results_checked  = 0;
    int            mismatches       = 0;
    int            settings_loaded  = 0;
    int            mode_hits [5]    = '{default: 0};
    int            idle_cycles      = 0;
    int            hold_order       = 0;
    int            hold_served      = 0;
    int            hold_left        = 0;
    bit            quiet            = 1'b0;
    logic [31:0]   stim_count       = '0;

    // ---------------------------------------------------------------
    // Sequencer prediction
    // ---------------------------------------------------------------

    // An angle is inside the window when its distance past the start, taken
    // around the turn, does not exceed the window span. Equal ends mean no window.
    function automatic logic in_safe_range(int m, angle_t a);
        angle_t s;
        angle_t e;
        int     span;
        int     past;
        s    = cfg_regs[int'(REG_LEFT_LIMIT_START) + 2 * m];
        e    = cfg_regs[int'(REG_LEFT_LIMIT_END) + 2 * m];
        span = (int'(e) - int'(s) + TURN) % TURN;
        past = (int'(a) - int'(s) + TURN) % TURN;
        return (s != e) && (past <= span);
    endfunction

    // In a window that wraps zero, angles below the start sit one turn higher.
    function automatic unw_t unwrap_angle(int m, angle_t a);
        angle_t s;
        angle_t e;
        s = cfg_regs[int'(REG_LEFT_LIMIT_START) + 2 * m];
        e = cfg_regs[int'(REG_LEFT_LIMIT_END) + 2 * m];
        if (s > e && a < s) begin
            return unw_t'(a) + unw_t'(TURN);
        end
        return unw_t'(a);
    endfunction

    function automatic angle_t target_of(int m, logic to_goal);
        return to_goal ? cfg_regs[int'(REG_LEFT_GOAL) + m] : cfg_regs[int'(REG_LEFT_HOME) + m];
    endfunction

    function automatic logic close_to(int m, angle_t target);
        int d;
        d = int'(unwrap_angle(m, target)) - int'(unw_q[m]);
        return (d <= ARRIVE_TOLERANCE) && (d >= -ARRIVE_TOLERANCE);
    endfunction

    // Arrival needs both feeds good this tick.
    function automatic logic arrived(logic [1:0] good, logic to_goal);
        return (good == 2'b11) && close_to(0, target_of(0, to_goal))
               && close_to(1, target_of(1, to_goal));
    endfunction

    function automatic logic config_valid();
        for (int m = 0; m < 2; m++) begin
            if (!in_safe_range(m, target_of(m, 1'b0)) || !in_safe_range(m, target_of(m, 1'b1))) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic void aim_setpoints();
        logic to_goal;
        to_goal = (mode_q == MODE_GOGOAL) || (mode_q == MODE_GOALHOLD);
        for (int m = 0; m < 2; m++) begin
            sp_q[m] = unwrap_angle(m, target_of(m, to_goal));
        end
    endfunction

    // Advance the shadow sequencer by one tick and return the result it produces.
    function automatic tick_out_t sequence_tick(tick_in_t t);
        tick_out_t  r;
        logic       ok;
        logic [1:0] good;
        angle_t     a [2];
        ok      = config_valid();
        a[0]    = t.left_pos;
        a[1]    = t.right_pos;
        good[0] = t.left_link_ok && in_safe_range(0, a[0]);
        good[1] = t.right_link_ok && in_safe_range(1, a[1]);

        if (!t.mechanism_on || !ok || good == 2'b00) begin
            // Shutdown: park on the home angles and absorb the action count.
            mode_q = MODE_OFF;
            seen_q = t.action_count;
            aim_setpoints();
        end else begin
            for (int m = 0; m < 2; m++) begin
                if (good[m]) begin
                    raw_q[m] = a[m];
                    unw_q[m] = unwrap_angle(m, a[m]);
                end
            end
            if (mode_q == MODE_OFF) begin
                mode_q = MODE_GOHOME;
                aim_setpoints();
                seen_q = t.action_count;
                if (arrived(good, 1'b0)) begin
                    mode_q = MODE_HOMEHOLD;
                end
            end else if (!t.stair_allowed) begin
                if (mode_q != MODE_HOMEHOLD || !arrived(good, 1'b0)) begin
                    mode_q = MODE_GOHOME;
                    aim_setpoints();
                end
                if (arrived(good, 1'b0)) begin
                    mode_q = MODE_HOMEHOLD;
                end
                seen_q = t.action_count;
            end else begin
                if (t.action_count != seen_q) begin
                    seen_q = t.action_count;
                    if (mode_q == MODE_HOMEHOLD || mode_q == MODE_GOHOME) begin
                        mode_q = MODE_GOGOAL;
                    end else begin
                        mode_q = MODE_GOHOME;
                    end
                    aim_setpoints();
                end
                if (mode_q == MODE_GOGOAL && arrived(good, 1'b1)) begin
                    mode_q = MODE_GOALHOLD;
                end else if ((mode_q == MODE_GOHOME || mode_q == MODE_HOMEHOLD)
                             && arrived(good, 1'b0)) begin
                    mode_q = MODE_HOMEHOLD;
                end
            end
        end

        r                = '0;
        r.mode           = mode_q;
        r.control_on     = (mode_q != MODE_OFF);
        r.config_ok      = ok;
        r.left_setpoint  = sp_q[0];
        r.right_setpoint = sp_q[1];
        r.left_feedback  = unw_q[0];
        r.right_feedback = unw_q[1];
        r.left_error     = {1'b0, sp_q[0]} - {1'b0, unw_q[0]};
        r.right_error    = {1'b0, sp_q[1]} - {1'b0, unw_q[1]};
        r.left_raw_kept  = raw_q[0];
        r.right_raw_kept = raw_q[1];
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Input driver: presents queued ticks, holds each until its transfer.
    // ---------------------------------------------------------------

    function automatic bit take_a_break();
        return !quiet && ($urandom_range(0, 99) < IDLE_PCT);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                results_due.push_back(sequence_tick(tick_in_t'(s_tdata)));
                ticks_taken++;
            end
            // A new tick may only be offered once the previous one has gone.
            if (!s_tvalid || s_tready) begin
                if (ticks_to_send.size() > 0 && !take_a_break()) begin
                    s_tdata  <= ticks_to_send.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Result monitor: checks every transfer against the oldest prediction and
    // throttles m_tready, including the long hold-off when one is ordered.
    // ---------------------------------------------------------------

    always @(posedge aclk) begin
        tick_out_t got;
        tick_out_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = tick_out_t'(m_tdata);
                if (results_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("[%0t] unexpected result with nothing pending: %p", $realtime, got);
                    end
                end else begin
                    want = results_due.pop_front();
                    results_checked++;
                    if (want.mode <= MODE_GOALHOLD) begin
                        mode_hits[want.mode]++;
                    end
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("[%0t] result %0d mismatch", $realtime, results_checked);
                            $display("    expected %p", want);
                            $display("    actual   %p", got);
                        end
                    end
                end
            end

            if (hold_order != hold_served) begin
                hold_served <= hold_order;
                hold_left   <= HOLD_CYCLES;
                m_tready    <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end else begin
                m_tready <= !take_a_break();
            end
        end
    end

    // ---------------------------------------------------------------
    // Watchdog: too long without any transfer on either channel ends the run.
    // ---------------------------------------------------------------

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("[%0t] no transfer for %0d cycles, %0d results still pending",
                     $realtime, idle_cycles, results_due.size());
            $display("two_joint_position_sequencer test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    task automatic write_reg(input reg_idx_t idx, input angle_t value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= value;
        cfg_regs[idx] = value;
    endtask

    // Registers change only here, and only while the block holds no tick.
    task automatic load_config(input angle_t ls, input angle_t le, input angle_t rs,
                               input angle_t re, input angle_t lh, input angle_t rh,
                               input angle_t lg, input angle_t rg);
        write_reg(REG_LEFT_LIMIT_START, ls);
        write_reg(REG_LEFT_LIMIT_END, le);
        write_reg(REG_RIGHT_LIMIT_START, rs);
        write_reg(REG_RIGHT_LIMIT_END, re);
        write_reg(REG_LEFT_HOME, lh);
        write_reg(REG_RIGHT_HOME, rh);
        write_reg(REG_LEFT_GOAL, lg);
        write_reg(REG_RIGHT_GOAL, rg);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        settings_loaded++;
        @(negedge aclk);
    endtask

    task automatic add_tick(input angle_t l, input angle_t r, input bit lok, input bit rok,
                            input bit on, input bit stair, input logic [31:0] cnt);
        tick_in_t t;
        t                = '0;
        t.left_pos       = l;
        t.right_pos      = r;
        t.left_link_ok   = lok;
        t.right_link_ok  = rok;
        t.mechanism_on   = on;
        t.stair_allowed  = stair;
        t.action_count   = cnt;
        ticks_to_send.push_back(t);
        ticks_queued++;
    endtask

    // Sender pause: nothing more is queued until every result has come back.
    task automatic wait_drained();
        @(negedge aclk);
        while (ticks_taken != ticks_queued || results_due.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    // Angle near one of the configured targets; a quarter land exactly on it.
    function automatic angle_t near_target(int m, logic to_goal);
        int off;
        off = 0;
        if ($urandom_range(0, 3) != 0) begin
            off = int'($urandom_range(0, 2 * SPREAD)) - SPREAD;
        end
        return angle_t'(int'(target_of(m, to_goal)) + off);
    endfunction

    function automatic angle_t pick_inside(angle_t s, angle_t e);
        int span;
        span = (int'(e) - int'(s) + TURN) % TURN;
        return angle_t'(int'(s) + int'($urandom_range(0, span)));
    endfunction

    // Mostly well-formed motion: both motors sit at home or goal, links good,
    // enable on and the action count steady, with new actions now and then.
    // The rest is noise: random angles, dropped links, shutdowns, count jumps.
    task automatic random_ticks(input int n);
        int      place;
        int      pick;
        angle_t  a [2];
        for (int i = 0; i < n; i++) begin
            place = $urandom_range(0, 9);
            for (int m = 0; m < 2; m++) begin
                if (place >= 8 || $urandom_range(0, 99) < 5) begin
                    a[m] = angle_t'($urandom_range(0, TURN - 1));
                end else begin
                    a[m] = near_target(m, place >= 4);
                end
            end
            pick = $urandom_range(0, 99);
            if (pick >= 95) begin
                stim_count = $urandom;
            end else if (pick >= 82) begin
                stim_count = stim_count + 1;
            end
            add_tick(a[0], a[1], $urandom_range(0, 99) < 93, $urandom_range(0, 99) < 93,
                     $urandom_range(0, 99) < 96, $urandom_range(0, 99) < 90, stim_count);
        end
    endtask

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------

    initial begin
        angle_t ls;
        angle_t le;
        angle_t rs;
        angle_t re;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Registers still at reset: no window, so every tick must shut down.
        add_tick('0, '0, 1'b1, 1'b1, 1'b1, 1'b1, '0);
        add_tick('1, '1, 1'b1, 1'b1, 1'b1, 1'b1, '1);
        add_tick(16'h5A5A, 16'hA5A5, 1'b0, 1'b0, 1'b0, 1'b0, 32'h5555_AAAA);
        wait_drained();

        // Left window wraps through zero, right window does not.
        load_config(16'd60000, 16'd12000, 16'd1000, 16'd40000,
                    16'd63000, 16'd1500, 16'd9000, 16'd30000);
        add_tick(16'd63000, 16'd1500, 1'b1, 1'b1, 1'b1, 1'b1, 32'd0);  // enable already home
        add_tick(16'd63000, 16'd1500, 1'b1, 1'b1, 1'b1, 1'b1, 32'd5);  // new action
        add_tick(16'd2000, 16'd20000, 1'b1, 1'b1, 1'b1, 1'b1, 32'd5);  // under way
        add_tick(16'd9365, 16'd30000, 1'b1, 1'b1, 1'b1, 1'b1, 32'd5);  // one unit too far
        add_tick(16'd9364, 16'd30000, 1'b1, 1'b1, 1'b1, 1'b1, 32'd5);  // on the tolerance edge
        add_tick(16'd9000, 16'd30000, 1'b1, 1'b1, 1'b1, 1'b1, 32'd6);  // back home
        add_tick(16'd63000, 16'd1500, 1'b0, 1'b1, 1'b1, 1'b1, 32'd6);  // link down blocks arrival
        add_tick(16'd30000, 16'd1500, 1'b1, 1'b1, 1'b1, 1'b1, 32'd6);  // left out of window
        add_tick(16'd0, 16'd65535, 1'b1, 1'b1, 1'b1, 1'b1, 32'd6);     // left unwraps, right out
        add_tick(16'd30000, 16'd65535, 1'b1, 1'b1, 1'b1, 1'b1, 32'd6); // both feeds bad
        add_tick(16'd65535, 16'd40000, 1'b1, 1'b1, 1'b1, 1'b1, 32'd7); // re-enable away from home
        add_tick(16'd63000, 16'd1500, 1'b1, 1'b1, 1'b1, 1'b1, 32'd8);
        add_tick(16'd9000, 16'd30000, 1'b1, 1'b1, 1'b1, 1'b0, 32'd9);  // stair withdrawn
        add_tick(16'd63000, 16'd1500, 1'b1, 1'b1, 1'b1, 1'b0, 32'd10);
        add_tick(16'd63000, 16'd1500, 1'b1, 1'b1, 1'b0, 1'b1, 32'd11); // mechanism off
        add_tick(16'd12000, 16'd1000, 1'b1, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
        add_tick(16'd60000, 16'd40000, 1'b1, 1'b1, 1'b1, 1'b1, 32'd0);
        stim_count = '0;
        random_ticks(250);
        wait_drained();

        // Extreme windows: the left one spans the whole turn, the right one wraps
        // and holds only the two angles at the ends. No idling in this phase.
        quiet = 1'b1;
        load_config(16'd0, 16'd65535, 16'd65535, 16'd0,
                    16'd0, 16'd65535, 16'd65535, 16'd0);
        random_ticks(100);
        wait_drained();
        quiet = 1'b0;

        // Empty left window, then a goal outside its window: config_ok stays low.
        load_config(16'd500, 16'd500, 16'd1000, 16'd40000,
                    16'd500, 16'd1500, 16'd500, 16'd30000);
        random_ticks(15);
        wait_drained();
        load_config(16'd1000, 16'd20000, 16'd50000, 16'd3000,
                    16'd2000, 16'd60000, 16'd30000, 16'd2000);
        random_ticks(15);
        wait_drained();

        // Random valid windows. The receiver holds off for a long stretch while
        // the sender keeps offering, so the pipeline fills and stalls its input.
        for (int k = 0; k < 3; k++) begin
            ls = angle_t'($urandom_range(0, TURN - 1));
            do begin
                le = angle_t'($urandom_range(0, TURN - 1));
            end while (le == ls);
            rs = angle_t'($urandom_range(0, TURN - 1));
            do begin
                re = angle_t'($urandom_range(0, TURN - 1));
            end while (re == rs);
            load_config(ls, le, rs, re, pick_inside(ls, le), pick_inside(rs, re),
                        pick_inside(ls, le), pick_inside(rs, re));
            random_ticks(60);
            if (k == 1) begin
                hold_order = hold_order + 1;
            end
            wait_drained();
        end

        // Anything that shows up now was never predicted.
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("Ran %0d ticks under %0d register settings, %0d results checked.",
                 ticks_taken, settings_loaded, results_checked);
        $display("Modes seen: off %0d, going home %0d, home hold %0d, going to goal %0d, goal hold %0d.",
                 mode_hits[MODE_OFF], mode_hits[MODE_GOHOME], mode_hits[MODE_HOMEHOLD],
                 mode_hits[MODE_GOGOAL], mode_hits[MODE_GOALHOLD]);
        if (mismatches == 0) begin
            $display("two_joint_position_sequencer test passed");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("two_joint_position_sequencer test failed");
        end
        $finish;
    end

endmodule
